// File: hdl/pidsd_pkg.sv
// ----------------------------------------------------------------------------
// pidsd_pkg
// Shared widths, register indexes, case codes and stage records for the
// incremental pid step with coarse band and dead band.
// ----------------------------------------------------------------------------
package pidsd_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int GAIN_W       = 16;
  localparam int BAND_W       = 16;
  localparam int LIMIT_W      = 15;
  localparam int DRIVE_W      = 16;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;

  localparam int ERR_W = SAMPLE_WIDTH + 1;
  localparam int CMP_W = ERR_W + 1;
  localparam int DP_W  = ERR_W + 1;
  localparam int DD_W  = ERR_W + 2;
  localparam int PP_W  = GAIN_W + 1 + DP_W;
  localparam int PI_W  = GAIN_W + 1 + ERR_W;
  localparam int PD_W  = GAIN_W + 1 + DD_W;
  localparam int SUM_W = PD_W + 2;

  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COARSE_BAND = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIM  = 3'd6;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = {LIMIT_W{1'b1}};

  typedef logic [2:0] kind_t;
  localparam kind_t KIND_HOLD = 3'd0;
  localparam kind_t KIND_POS  = 3'd1;
  localparam kind_t KIND_NEG  = 3'd2;
  localparam kind_t KIND_ZERO = 3'd3;
  localparam kind_t KIND_PID  = 3'd4;

  typedef struct packed {
    logic [SAMPLE_WIDTH-1:0] setpoint;
    logic [GAIN_W-1:0]       gain_p;
    logic [GAIN_W-1:0]       gain_i;
    logic [GAIN_W-1:0]       gain_d;
    logic [BAND_W-1:0]       coarse_band;
    logic [BAND_W-1:0]       dead_band;
    logic [LIMIT_W-1:0]      output_limit;
  } cfg_t;

  typedef struct packed {
    kind_t                   kind;
    logic signed [ERR_W-1:0] e0;
    logic signed [DP_W-1:0]  dp;
    logic signed [DD_W-1:0]  dd;
  } err_t;

  typedef struct packed {
    kind_t                  kind;
    logic signed [PP_W-1:0] prod_p;
    logic signed [PI_W-1:0] prod_i;
    logic signed [PD_W-1:0] prod_d;
  } prod_t;

endpackage

// File: hdl/pidsd_cfg.sv
// ----------------------------------------------------------------------------
// pidsd_cfg
// Configuration register file with index decode and field masking.
// ----------------------------------------------------------------------------
module pidsd_cfg
  import pidsd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{setpoint: '0, gain_p: '0, gain_i: '0, gain_d: '0,
               coarse_band: '0, dead_band: '0, output_limit: LIMIT_RESET};
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SETPOINT:    cfg.setpoint     <= cfg_data[SAMPLE_WIDTH-1:0];
        REG_GAIN_P:      cfg.gain_p       <= cfg_data[GAIN_W-1:0];
        REG_GAIN_I:      cfg.gain_i       <= cfg_data[GAIN_W-1:0];
        REG_GAIN_D:      cfg.gain_d       <= cfg_data[GAIN_W-1:0];
        REG_COARSE_BAND: cfg.coarse_band  <= cfg_data[BAND_W-1:0];
        REG_DEAD_BAND:   cfg.dead_band    <= cfg_data[BAND_W-1:0];
        REG_OUTPUT_LIM:  cfg.output_limit <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: hdl/pidsd_err_stage.sv
// ----------------------------------------------------------------------------
// pidsd_err_stage
// Forms the error, picks the band case, keeps the error history and
// registers the differences for the multiplier stage.
// ----------------------------------------------------------------------------
module pidsd_err_stage
  import pidsd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  cfg_t                    cfg,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [SAMPLE_WIDTH-1:0] measured,
  output logic                    out_valid,
  input  logic                    out_ready,
  output err_t                    out_data
);

  logic signed [ERR_W-1:0] hist0;
  logic signed [ERR_W-1:0] hist1;
  logic signed [ERR_W-1:0] err;
  logic signed [CMP_W-1:0] err_x;
  logic signed [CMP_W-1:0] cb_x;
  logic signed [CMP_W-1:0] db_x;
  logic                    load;
  err_t                    data_next;

  assign in_ready = !out_valid || out_ready;
  assign load     = in_valid && in_ready;

  always_comb begin
    err   = $signed({1'b0, cfg.setpoint}) - $signed({1'b0, measured});
    err_x = CMP_W'(err);
    cb_x  = $signed(CMP_W'(cfg.coarse_band));
    db_x  = $signed(CMP_W'(cfg.dead_band));
    data_next.e0 = err;
    data_next.dp = DP_W'(err) - DP_W'(hist0);
    data_next.dd = DD_W'(err) + DD_W'(hist1) - (DD_W'(hist0) <<< 1);
    if (err == '0) begin
      data_next.kind = KIND_HOLD;
    end else if (err_x > cb_x) begin
      data_next.kind = KIND_POS;
    end else if (err_x < -cb_x) begin
      data_next.kind = KIND_NEG;
    end else if (err_x < db_x && err_x > -db_x) begin
      data_next.kind = KIND_ZERO;
    end else begin
      data_next.kind = KIND_PID;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      hist0     <= '0;
      hist1     <= '0;
    end else begin
      if (in_ready) begin
        out_valid <= in_valid;
      end
      if (load && data_next.kind == KIND_PID) begin
        hist0 <= err;
        hist1 <= hist0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= data_next;
    end
  end

endmodule

// File: hdl/pidsd_mul_stage.sv
// ----------------------------------------------------------------------------
// pidsd_mul_stage
// Three parallel gain multiplies with a register after each product.
// ----------------------------------------------------------------------------
module pidsd_mul_stage
  import pidsd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  logic  in_valid,
  output logic  in_ready,
  input  err_t  in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output prod_t out_data
);

  prod_t data_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    data_next.kind   = in_data.kind;
    data_next.prod_p = PP_W'($signed({1'b0, cfg.gain_p})) * PP_W'(in_data.dp);
    data_next.prod_i = PI_W'($signed({1'b0, cfg.gain_i})) * PI_W'(in_data.e0);
    data_next.prod_d = PD_W'($signed({1'b0, cfg.gain_d})) * PD_W'(in_data.dd);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= data_next;
    end
  end

endmodule

// File: hdl/pidsd_out_stage.sv
// ----------------------------------------------------------------------------
// pidsd_out_stage
// Sums the products, saturates to the limit and holds the drive register,
// which also serves as the last drive for the hold case.
// ----------------------------------------------------------------------------
module pidsd_out_stage
  import pidsd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  prod_t              in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [DRIVE_W-1:0] drive
);

  logic signed [SUM_W-1:0]   sum;
  logic signed [SUM_W-1:0]   lim_x;
  logic signed [DRIVE_W-1:0] lim_d;
  logic [DRIVE_W-1:0]        drive_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    sum   = SUM_W'(in_data.prod_p) + SUM_W'(in_data.prod_i) + SUM_W'(in_data.prod_d);
    lim_x = $signed(SUM_W'(cfg.output_limit));
    lim_d = $signed(DRIVE_W'(cfg.output_limit));
    case (in_data.kind)
      KIND_HOLD: drive_next = drive;
      KIND_POS:  drive_next = lim_d;
      KIND_NEG:  drive_next = -lim_d;
      KIND_ZERO: drive_next = '0;
      KIND_PID: begin
        if (sum > lim_x) begin
          drive_next = lim_d;
        end else if (sum < -lim_x) begin
          drive_next = -lim_d;
        end else begin
          drive_next = sum[DRIVE_W-1:0];
        end
      end
      default: drive_next = drive;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      drive     <= '0;
    end else begin
      if (in_ready) begin
        out_valid <= in_valid;
      end
      if (in_valid && in_ready) begin
        drive <= drive_next;
      end
    end
  end

endmodule

// File: hdl/pid_step_with_deadband.sv
// ----------------------------------------------------------------------------
// pid_step_with_deadband
// Incremental pid step with coarse band and dead band, one drive per sample.
// throughput: one sample per cycle unless out_ready stalls the three-stage pipeline
// (error and band stage, gain multiply stage, sum and saturate stage)
// reset: synchronous, clears pipeline, error history and drive; limit 32767
// ----------------------------------------------------------------------------
module pid_step_with_deadband
  import pidsd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [SAMPLE_WIDTH-1:0] measured,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [DRIVE_W-1:0]      drive
);

  cfg_t  cfg;
  err_t  err_data;
  prod_t prod_data;
  logic  err_valid;
  logic  err_ready;
  logic  prod_valid;
  logic  prod_ready;

  pidsd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pidsd_err_stage u_err (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .measured  (measured),
    .out_valid (err_valid),
    .out_ready (err_ready),
    .out_data  (err_data)
  );

  pidsd_mul_stage u_mul (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (err_valid),
    .in_ready  (err_ready),
    .in_data   (err_data),
    .out_valid (prod_valid),
    .out_ready (prod_ready),
    .out_data  (prod_data)
  );

  pidsd_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (prod_valid),
    .in_ready  (prod_ready),
    .in_data   (prod_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .drive     (drive)
  );

endmodule

// File: hdl/pidsd_checker.sv
// ----------------------------------------------------------------------------
// pidsd_checker
// Port-level checks of the pid step block, bound to the top level.
// ----------------------------------------------------------------------------
module pidsd_checker
  import pidsd_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               cfg_ready,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [DRIVE_W-1:0] drive
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(drive))
    else $error("drive changed while stalled");

  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> drive != {1'b1, {(DRIVE_W-1){1'b0}}})
    else $error("drive outside symmetric range");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("config port not ready");

  a_in_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty result");

endmodule

bind pid_step_with_deadband pidsd_checker u_checker (.*);
